### rtl/core/nmea_sf_pkg.sv
// ----------------------------------------------------------------------------
// nmea_sf_pkg: shared constants for the NMEA sentence framer
// Event codes, framing characters, reset address words and field limit.
// ----------------------------------------------------------------------------
package nmea_sf_pkg;

  localparam int unsigned MAX_FIELD_INDEX = 31;
  localparam int unsigned FIELD_W         = 5;
  localparam int unsigned ADDR_W          = 40;
  localparam int unsigned ADDR_CHARS      = 5;

  // Field index stops at the smaller of the limit and the largest 5-bit value
  localparam logic [FIELD_W-1:0] FIELD_LIMIT =
    FIELD_W'((MAX_FIELD_INDEX < 31) ? MAX_FIELD_INDEX : 31);

  // Result event codes
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_BYTE   = 3'd1;
  localparam logic [2:0] EV_FEND   = 3'd2;
  localparam logic [2:0] EV_ACCEPT = 3'd3;
  localparam logic [2:0] EV_ERROR  = 3'd4;
  localparam logic [2:0] EV_IGNORE = 3'd5;

  // Sentence type codes
  localparam logic [1:0] TYPE_NONE   = 2'd0;
  localparam logic [1:0] TYPE_FIRST  = 2'd1;
  localparam logic [1:0] TYPE_SECOND = 2'd2;

  // Configuration register indexes
  localparam logic REG_FIRST_ADDR  = 1'b0;
  localparam logic REG_SECOND_ADDR = 1'b1;

  // Framing characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // Reset address words: "GPRMC" and "GPGGA", first character in top byte
  localparam logic [ADDR_W-1:0] FIRST_ADDR_RST  = 40'h4750524D43;
  localparam logic [ADDR_W-1:0] SECOND_ADDR_RST = 40'h4750474741;

endpackage

### rtl/core/nmea_sentence_framer_unit.sv
// ----------------------------------------------------------------------------
// nmea_sentence_framer_unit: NMEA 0183 sentence framer
// Frames received characters into sentences and reports per-character events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/rx_byte) takes one received character
//   per word. Every accepted character yields exactly one result word on the
//   output channel (out_valid/out_ready and the result fields); characters
//   with nothing to report give event code "nothing".
//   Latency: the result for a character is valid the cycle after it is
//   accepted. Throughput: one word per cycle while the receiver does not
//   stall, set by the single output register; all parsing is one short
//   combinational pass from the parse state and the incoming character.
//   Stall: in_ready = !out_valid || out_ready, so a new character is taken in
//   the same cycle the held result leaves. While the receiver stalls the
//   result holds and no input is taken.
//   Reset (rst, synchronous): parser back to idle, output empty, both address
//   words back to "GPRMC" and "GPGGA".
//   Configuration: wr_en/wr_index/wr_data write an address word, which the
//   user must do only while the framer is idle; the block does not enforce it.
//   Index 0 is type 1, index 1 type 2; the checksum is skipped, not verified.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_unit
  import nmea_sf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [ADDR_W-1:0]  wr_data,
  // character input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  // result output
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         event_res,
  output logic [1:0]         sentence_type,
  output logic [FIELD_W-1:0] field_index,
  output logic [7:0]         field_byte,
  output logic               last_field
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_ADDR = 3'd1,
    ST_DATA = 3'd2,
    ST_CSUM = 3'd3,
    ST_CR   = 3'd4,
    ST_LF   = 3'd5
  } stage_t;

  stage_t              parse_stage, parse_stage_next;
  logic [2:0]          char_count, char_count_next;
  logic [1:0]          current_type, current_type_next;
  logic [FIELD_W-1:0]  current_field, current_field_next;
  logic [ADDR_W-1:0]   address_shift, address_shift_next;
  logic [ADDR_W-1:0]   first_address, second_address;

  logic [2:0]          ev_next;
  logic [1:0]          type_next;
  logic [FIELD_W-1:0]  index_next;
  logic [7:0]          byte_next;
  logic                last_next;

  logic                in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Parse step for one character
  always_comb begin
    parse_stage_next   = parse_stage;
    char_count_next    = char_count;
    current_type_next  = current_type;
    current_field_next = current_field;
    address_shift_next = address_shift;
    ev_next            = EV_NONE;
    type_next          = TYPE_NONE;
    index_next         = '0;
    byte_next          = '0;
    last_next          = 1'b0;

    case (parse_stage)
      ST_ADDR: begin
        if (char_count < 3'(ADDR_CHARS)) begin
          address_shift_next = {address_shift[ADDR_W-9:0], rx_byte};
          char_count_next    = char_count + 3'd1;
        end else begin
          // first address wins when both match
          if (address_shift == first_address) begin
            current_type_next = TYPE_FIRST;
          end else if (address_shift == second_address) begin
            current_type_next = TYPE_SECOND;
          end
          if (address_shift != first_address && address_shift != second_address) begin
            parse_stage_next = ST_IDLE;
            ev_next          = EV_IGNORE;
          end else if (rx_byte == CH_COMMA) begin
            parse_stage_next   = ST_DATA;
            char_count_next    = '0;
            current_field_next = '0;
          end else begin
            parse_stage_next = ST_IDLE;
            ev_next          = EV_ERROR;
            type_next        = current_type_next;
          end
        end
      end
      ST_DATA: begin
        type_next  = current_type;
        index_next = current_field;
        if (rx_byte == CH_STAR) begin
          ev_next            = EV_FEND;
          last_next          = 1'b1;
          parse_stage_next   = ST_CSUM;
          char_count_next    = '0;
          current_field_next = '0;
        end else if (rx_byte == CH_COMMA) begin
          ev_next = EV_FEND;
          if (current_field < FIELD_LIMIT) begin
            current_field_next = current_field + 1'b1;
          end
        end else begin
          ev_next   = EV_BYTE;
          byte_next = rx_byte;
        end
      end
      ST_CSUM: begin
        if (char_count < 3'd1) begin
          char_count_next = char_count + 3'd1;
        end else begin
          ev_next          = EV_ACCEPT;
          type_next        = current_type;
          parse_stage_next = ST_CR;
        end
      end
      ST_CR: begin
        if (rx_byte == CH_CR) begin
          parse_stage_next = ST_LF;
        end else begin
          ev_next          = EV_ERROR;
          type_next        = current_type;
          parse_stage_next = ST_IDLE;
        end
      end
      ST_LF: begin
        if (rx_byte != CH_LF) begin
          ev_next   = EV_ERROR;
          type_next = current_type;
        end
        parse_stage_next = ST_IDLE;
      end
      default: begin
        parse_stage_next = ST_IDLE;
        if (rx_byte == CH_DOLLAR) begin
          parse_stage_next   = ST_ADDR;
          char_count_next    = '0;
          address_shift_next = '0;
        end
      end
    endcase
  end

  // State, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_stage    <= ST_IDLE;
      char_count     <= '0;
      current_type   <= TYPE_NONE;
      current_field  <= '0;
      address_shift  <= '0;
      first_address  <= FIRST_ADDR_RST;
      second_address <= SECOND_ADDR_RST;
      out_valid      <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_FIRST_ADDR:  first_address  <= wr_data;
          REG_SECOND_ADDR: second_address <= wr_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        parse_stage   <= parse_stage_next;
        char_count    <= char_count_next;
        current_type  <= current_type_next;
        current_field <= current_field_next;
        address_shift <= address_shift_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted character
  always_ff @(posedge clk) begin
    if (in_fire) begin
      event_res     <= ev_next;
      sentence_type <= type_next;
      field_index   <= index_next;
      field_byte    <= byte_next;
      last_field    <= last_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_data_event: assert property (@(posedge clk) disable iff (rst)
    (in_fire && parse_stage == ST_DATA) |=>
      (out_valid && (event_res == EV_BYTE || event_res == EV_FEND)))
    else $error("data character did not give a field event");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_fire && parse_stage == ST_IDLE && rx_byte == CH_DOLLAR) |=>
      (parse_stage == ST_ADDR && char_count == 3'd0 && address_shift == '0))
    else $error("sentence start not taken");

  a_accept_stage: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_ACCEPT) |-> (parse_stage == ST_CR))
    else $error("accepted sentence without waiting for CR");

  a_field_limit: assert property (@(posedge clk) disable iff (rst)
    (current_field <= FIELD_LIMIT))
    else $error("field index beyond limit");

endmodule

### test/tb_nmea_sentence_framer_unit.sv
// ----------------------------------------------------------------------------
// tb_nmea_sentence_framer_unit: self-checking bench for the NMEA framer
// Feeds character streams (directed sentences, then random well-formed,
// broken and noise traffic) through valid/ready with random sender gaps and
// receiver stalls. An in-bench model of the framer predicts one event word
// per accepted character; a monitor compares each output word field by field.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_framer_unit
  import nmea_sf_pkg::*;
;

  // Cap of the field counter: the smaller of the limit and the 5-bit maximum
  localparam logic [FIELD_W-1:0] FIELD_CAP =
    FIELD_W'((MAX_FIELD_INDEX < 31) ? MAX_FIELD_INDEX : 31);

  // Long receiver hold-off, in cycles
  localparam int HOLD_CYCLES = 300;

  // Parser stages of the model
  typedef enum logic [2:0] {
    PS_IDLE, PS_ADDR, PS_DATA, PS_CSUM, PS_CR, PS_LF
  } frame_stage_t;

  // One expected output word
  typedef struct packed {
    logic [2:0]         ev;
    logic [1:0]         ty;
    logic [FIELD_W-1:0] idx;
    logic [7:0]         fb;
    logic               lf;
  } frame_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              wr_en    = 1'b0;
  logic              wr_index = 1'b0;
  logic [ADDR_W-1:0] wr_data  = '0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        rx_byte  = 8'h00;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         event_res;
  logic [1:0]         sentence_type;
  logic [FIELD_W-1:0] field_index;
  logic [7:0]         field_byte;
  logic               last_field;

  nmea_sentence_framer_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_res     (event_res),
    .sentence_type (sentence_type),
    .field_index   (field_index),
    .field_byte    (field_byte),
    .last_field    (last_field)
  );

  // 20-unit clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Framer model state and configuration copy
  // --------------------------------------------------------------------------
  frame_stage_t      frm_stage = PS_IDLE;
  int unsigned       frm_count = 0;
  logic [1:0]        frm_kind  = TYPE_NONE;
  logic [FIELD_W-1:0] frm_field = '0;
  logic [ADDR_W-1:0] addr_acc  = '0;
  logic [ADDR_W-1:0] addr_word_first  = FIRST_ADDR_RST;
  logic [ADDR_W-1:0] addr_word_second = SECOND_ADDR_RST;

  frame_word_t pending_events[$];   // expected words, oldest first
  int          framed_chars = 0;    // chars the parser actually looked at
  int          sent_chars   = 0;    // every accepted char
  int          fail_count   = 0;

  // Sender burst state and receiver hold-off request
  int burst_left = 0;
  bit hold_req   = 1'b0;
  int hold_left  = 0;
  int pat_left   = 0;
  int pat_mode   = 0;

  // Advance the model by one accepted character and queue the expected word.
  function automatic void predict_event(input logic [7:0] c);
    frame_word_t w;
    w = '0;
    // idle chars other than '$' are just dropped; don't count them
    if (frm_stage != PS_IDLE || c == CH_DOLLAR) framed_chars++;
    case (frm_stage)
      PS_ADDR: begin
        if (frm_count < ADDR_CHARS) begin
          addr_acc  = {addr_acc[ADDR_W-9:0], c};
          frm_count = frm_count + 1;
        end else if (addr_acc != addr_word_first && addr_acc != addr_word_second) begin
          // unknown talker/type: drop the sentence, type stays untouched
          frm_stage = PS_IDLE;
          w.ev      = EV_IGNORE;
        end else begin
          // first register wins when both words are equal
          frm_kind = (addr_acc == addr_word_first) ? TYPE_FIRST : TYPE_SECOND;
          if (c == CH_COMMA) begin
            frm_stage = PS_DATA;
            frm_count = 0;
            frm_field = '0;
          end else begin
            frm_stage = PS_IDLE;
            w.ev      = EV_ERROR;
            w.ty      = frm_kind;
          end
        end
      end
      PS_DATA: begin
        w.ty  = frm_kind;
        w.idx = frm_field;
        if (c == CH_STAR) begin
          w.ev      = EV_FEND;
          w.lf      = 1'b1;
          frm_stage = PS_CSUM;
          frm_count = 0;
          frm_field = '0;
        end else if (c == CH_COMMA) begin
          w.ev = EV_FEND;
          if (frm_field < FIELD_CAP) frm_field = frm_field + 1'b1;
        end else begin
          // '$', CR and LF are plain data here
          w.ev = EV_BYTE;
          w.fb = c;
        end
      end
      PS_CSUM: begin
        // two checksum chars, not verified
        if (frm_count < 1) begin
          frm_count = frm_count + 1;
        end else begin
          w.ev      = EV_ACCEPT;
          w.ty      = frm_kind;
          frm_stage = PS_CR;
        end
      end
      PS_CR: begin
        if (c == CH_CR) begin
          frm_stage = PS_LF;
        end else begin
          w.ev      = EV_ERROR;
          w.ty      = frm_kind;
          frm_stage = PS_IDLE;
        end
      end
      PS_LF: begin
        if (c != CH_LF) begin
          w.ev = EV_ERROR;
          w.ty = frm_kind;
        end
        frm_stage = PS_IDLE;
      end
      default: begin
        frm_stage = PS_IDLE;
        if (c == CH_DOLLAR) begin
          frm_stage = PS_ADDR;
          frm_count = 0;
          addr_acc  = '0;
        end
      end
    endcase
    pending_events = {pending_events, w};
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one character per handshake, bursts with random gaps
  // --------------------------------------------------------------------------
  task automatic put_char(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      // about a quarter of the bursts follow straight on
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    rx_byte  = c;
    // handshake values are the pre-edge ones in the active region
    do @(posedge clk); while (!in_ready);
    sent_chars++;
    predict_event(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  // '$' plus five address chars, first char from the top byte
  task automatic send_header(input logic [ADDR_W-1:0] a);
    put_char(CH_DOLLAR);
    for (int i = 4; i >= 0; i--) put_char(a[i*8 +: 8]);
  endtask

  task automatic send_line_end();
    put_char(CH_CR);
    put_char(CH_LF);
  endtask

  // Drop valid and wait until every expected word has come out.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  // Push the parser back to idle: close data with '*', anything else with a
  // char that cannot start a sentence.
  task automatic return_to_idle();
    while (frm_stage != PS_IDLE)
      put_char((frm_stage == PS_DATA) ? CH_STAR : 8'h78);
  endtask

  task automatic write_addr(input logic idx, input logic [ADDR_W-1:0] val);
    return_to_idle();
    settle();
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = val;
    @(negedge clk);
    wr_en = 1'b0;
    if (idx == REG_FIRST_ADDR) addr_word_first = val;
    else addr_word_second = val;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall pattern is redrawn whenever its run counter expires; a
  // hold-off request blocks it until the hold counter, set here, runs out.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (pat_left == 0) begin
      pat_mode = $urandom_range(0, 3);
      pat_left = $urandom_range(16, 96);
    end
    pat_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      case (pat_mode)
        0:       out_ready = 1'b1;                         // no stalls
        1:       out_ready = ($urandom_range(0, 3) != 0);  // light
        2:       out_ready = ($urandom_range(0, 3) == 0);  // heavy
        default: out_ready = pat_left[0];                  // alternating
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t mismatch %s: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    frame_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        fail_count++;
        $display("%0t unexpected word: event %0d type %0d index %0d byte %0d last %0d",
                 $time, event_res, sentence_type, field_index, field_byte, last_field);
      end else begin
        w = pending_events.pop_front();
        check_field("event_res",     w.ev,  event_res);
        check_field("sentence_type", w.ty,  sentence_type);
        check_field("field_index",   w.idx, field_index);
        check_field("field_byte",    w.fb,  field_byte);
        check_field("last_field",    w.lf,  last_field);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Reset address words: a GPRMC and a GPGGA sentence, one with an empty field
  task automatic test_default_addresses();
    send_text("$GPRMC,12,A*5C");
    send_line_end();
    send_text("$GPGGA,,9*00");
    send_line_end();
  endtask

  // Unknown address, bad separator, '$' right after the address
  task automatic test_address_outcomes();
    send_text("$GPXXX,1*00");     // ignored, rest falls into idle
    send_line_end();
    send_text("$GPRMC;");         // framing error
    send_text("$GPGGA$GPRMC,7*00"); // '$' is consumed as a bad separator
    send_line_end();
  endtask

  // Control chars and byte extremes inside a field
  task automatic test_data_controls();
    send_text("$GPRMC,");
    put_char(CH_DOLLAR);
    put_char(CH_CR);
    put_char(CH_LF);
    put_char(8'h00);
    put_char(8'hFF);
    send_text("*00");
    send_line_end();
  endtask

  // Wrong char where CR belongs, then CR followed by a non-LF
  task automatic test_trailer_errors();
    send_text("$GPRMC,A*00X");
    send_text("$GPGGA,B*11");
    put_char(CH_CR);
    put_char(8'h5A);
  endtask

  // Forty-one commas, forty of them between fields: index must stick at the cap
  task automatic test_field_saturation();
    send_text("$GPRMC");
    repeat (41) put_char(CH_COMMA);
    send_text("*00");
    send_line_end();
  endtask

  // Receiver holds off while the sender keeps offering: input must stall
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (3) begin
      send_text("$GPGGA,1,22,333*4A");
      send_line_end();
    end
  endtask

  // Address word extremes: both zero (equal, type 1 wins), then all ones
  task automatic test_address_registers();
    write_addr(REG_FIRST_ADDR, '0);
    write_addr(REG_SECOND_ADDR, '0);
    send_header('0);
    send_text(",Q*00");
    send_line_end();
    write_addr(REG_SECOND_ADDR, '1);
    send_header('1);
    send_text(",R,S*00");
    send_line_end();
    send_text("$GPRMC,T*00");    // no longer a known address
    send_line_end();
  endtask

  // --------------------------------------------------------------------------
  // Random traffic
  // --------------------------------------------------------------------------

  // One sentence with random content; when broken, one part of the framing
  // goes wrong (separator, truncation, CR or LF).
  task automatic send_random_sentence(input bit broken);
    logic [ADDR_W-1:0] a;
    int fault;
    int nf;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4)      a = addr_word_first;
    else if (pick < 8) a = addr_word_second;
    else               a = {$urandom(), 8'($urandom())};
    fault = broken ? $urandom_range(1, 4) : 0;
    nf = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
    send_header(a);
    put_char((fault == 1) ? 8'($urandom()) : CH_COMMA);
    for (int f = 0; f < nf; f++) begin
      repeat ($urandom_range(0, 5)) put_char(8'($urandom()));
      if (f < nf - 1) put_char(CH_COMMA);
    end
    if (fault == 2) return;       // cut short: next '$' lands in the data
    put_char(CH_STAR);
    put_char(8'($urandom()));
    put_char(8'($urandom()));
    put_char((fault == 3) ? 8'($urandom()) : CH_CR);
    put_char((fault == 4) ? 8'($urandom()) : CH_LF);
  endtask

  // Random part adds about 480 chars on top of the directed ones
  task automatic test_random_traffic();
    int start;
    int next_cfg;
    int kind;
    logic [ADDR_W-1:0] v;
    start    = sent_chars;
    next_cfg = framed_chars;
    while (sent_chars - start < 480) begin
      if (framed_chars >= next_cfg) begin
        next_cfg = framed_chars + $urandom_range(80, 160);
        kind = $urandom_range(0, 4);
        case (kind)
          0: begin   // two arbitrary words
            write_addr(REG_FIRST_ADDR,  {$urandom(), 8'($urandom())});
            write_addr(REG_SECOND_ADDR, {$urandom(), 8'($urandom())});
          end
          1: begin   // "GP" plus three random capitals, per word
            for (int r = 0; r < 2; r++) begin
              v = {8'h47, 8'h50, 8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                   8'($urandom_range(65, 90))};
              write_addr(r[0], v);
            end
          end
          2: begin   // equal words
            v = {$urandom(), 8'($urandom())};
            write_addr(REG_FIRST_ADDR, v);
            write_addr(REG_SECOND_ADDR, v);
          end
          3: begin   // back to the reset words
            write_addr(REG_FIRST_ADDR, FIRST_ADDR_RST);
            write_addr(REG_SECOND_ADDR, SECOND_ADDR_RST);
          end
          default: begin  // one all ones, one zero
            write_addr(REG_FIRST_ADDR, '1);
            write_addr(REG_SECOND_ADDR, '0);
          end
        endcase
      end
      pick_traffic: begin
        int r;
        r = $urandom_range(0, 19);
        if (r < 15)      send_random_sentence(1'b0);
        else if (r < 18) send_random_sentence(1'b1);
        else repeat ($urandom_range(1, 5)) put_char(8'($urandom()));  // line noise
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_addresses();
    test_address_outcomes();
    test_data_controls();
    test_trailer_errors();
    test_field_saturation();
    test_backpressure();
    test_address_registers();
    test_random_traffic();

    // drain, then give a stray late word a chance to show up
    settle();
    repeat (10) @(posedge clk);
    if (pending_events.size() != 0) begin
      fail_count++;
      $display("%0t %0d expected words never came out", $time, pending_events.size());
    end
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
